>>> sv/smrf_pkg.sv
// ----------------------------------------------------------------------------
// smrf_pkg
// Shared types, access codes and reset values of the sm83 register file.
// ----------------------------------------------------------------------------
package smrf_pkg;

  // access codes
  localparam logic [3:0] ACT_RD8      = 4'd0;
  localparam logic [3:0] ACT_WR8      = 4'd1;
  localparam logic [3:0] ACT_RD16     = 4'd2;
  localparam logic [3:0] ACT_WR16     = 4'd3;
  localparam logic [3:0] ACT_RDSTK    = 4'd4;
  localparam logic [3:0] ACT_WRSTK    = 4'd5;
  localparam logic [3:0] ACT_POINTER  = 4'd6;
  localparam logic [3:0] ACT_COND     = 4'd7;
  localparam logic [3:0] ACT_SETFLAGS = 4'd8;
  localparam logic [3:0] ACT_FETCHPC  = 4'd9;

  // r8 codes
  localparam logic [2:0] R8_B   = 3'd0;
  localparam logic [2:0] R8_C   = 3'd1;
  localparam logic [2:0] R8_D   = 3'd2;
  localparam logic [2:0] R8_E   = 3'd3;
  localparam logic [2:0] R8_H   = 3'd4;
  localparam logic [2:0] R8_L   = 3'd5;
  localparam logic [2:0] R8_MEM = 3'd6;
  localparam logic [2:0] R8_A   = 3'd7;

  // pair codes (low two bits of reg_code)
  localparam logic [1:0] PAIR_BC  = 2'd0;
  localparam logic [1:0] PAIR_DE  = 2'd1;
  localparam logic [1:0] PAIR_HL  = 2'd2;
  localparam logic [1:0] PAIR_TOP = 2'd3;  // SP, AF or HL- by action

  // condition codes
  localparam logic [1:0] COND_NZ = 2'd0;
  localparam logic [1:0] COND_Z  = 2'd1;
  localparam logic [1:0] COND_NC = 2'd2;
  localparam logic [1:0] COND_C  = 2'd3;

  // flag operations
  localparam logic [1:0] FOP_CLEAR = 2'd0;
  localparam logic [1:0] FOP_SET   = 2'd1;

  // flag bit positions in F
  localparam int FLAG_Z_BIT = 7;
  localparam int FLAG_N_BIT = 6;
  localparam int FLAG_H_BIT = 5;
  localparam int FLAG_C_BIT = 4;

  localparam logic [7:0] F_HI_MASK = 8'hF0;

  // reset values
  localparam logic [7:0]  RST_A  = 8'h01;
  localparam logic [7:0]  RST_B  = 8'h00;
  localparam logic [7:0]  RST_C  = 8'h13;
  localparam logic [7:0]  RST_D  = 8'h00;
  localparam logic [7:0]  RST_E  = 8'hD8;
  localparam logic [7:0]  RST_H  = 8'h01;
  localparam logic [7:0]  RST_L  = 8'h4D;
  localparam logic [15:0] RST_SP = 16'hFFFE;
  localparam logic [15:0] RST_PC = 16'h0100;
  localparam logic [7:0]  RST_F_BASE  = 8'b1000_0000;
  localparam logic [7:0]  RST_F_EXTRA = 8'b0011_0000;

  typedef struct packed {
    logic [1:0]  carry_op;
    logic [1:0]  half_carry_op;
    logic [1:0]  subtract_op;
    logic [1:0]  zero_op;
    logic [1:0]  cond_code;
    logic [15:0] write_value;
    logic [2:0]  reg_code;
    logic [3:0]  action;
  } item_t;

  typedef struct packed {
    logic        bad_code;
    logic        cond_true;
    logic [15:0] read_data;
  } result_t;

  function automatic logic [7:0] flags_reset(input logic checksum_zero);
    return checksum_zero ? RST_F_BASE : (RST_F_BASE | RST_F_EXTRA);
  endfunction

  function automatic logic flag_apply(input logic cur, input logic [1:0] op);
    logic v;
    v = cur;
    if (op == FOP_SET) v = 1'b1;
    else if (op == FOP_CLEAR) v = 1'b0;
    return v;
  endfunction

endpackage

>>> sv/smrf_in_reg.sv
// ----------------------------------------------------------------------------
// smrf_in_reg
// Input register: holds one access item until the execute stage takes it.
// ----------------------------------------------------------------------------
module smrf_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  smrf_pkg::item_t in_item,
  output logic           item_vld,
  output smrf_pkg::item_t item,
  input  logic           item_take
);
  import smrf_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;

  // refill in the same cycle the held item moves on
  assign in_tready = !vld_r || item_take;
  assign vld_nxt   = (in_tvalid && in_tready) || (vld_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

>>> sv/smrf_exec.sv
// ----------------------------------------------------------------------------
// smrf_exec
// Architectural registers, access decode and the result register.
// ----------------------------------------------------------------------------
module smrf_exec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             item_vld,
  input  smrf_pkg::item_t  item,
  output logic             item_take,
  output logic             out_tvalid,
  input  logic             out_tready,
  output smrf_pkg::result_t result
);
  import smrf_pkg::*;

  logic [7:0]  a_r, f_r, b_r, c_r, d_r, e_r, h_r, l_r;
  logic [7:0]  a_nxt, f_nxt, b_nxt, c_nxt, d_nxt, e_nxt, h_nxt, l_nxt;
  logic [15:0] sp_r, pc_r, sp_nxt, pc_nxt;
  logic        ovld_r, ovld_nxt;
  result_t     res_r, res_nxt;

  logic        pair_ok;
  logic [1:0]  pair;
  logic [15:0] hl;
  logic [15:0] hl_step;
  logic [15:0] pair_rd;
  logic [15:0] stk_rd;

  assign item_take = item_vld && (!ovld_r || out_tready);
  assign ovld_nxt  = item_take || (ovld_r && !out_tready);

  assign pair_ok = (item.reg_code[2] == 1'b0);
  assign pair    = item.reg_code[1:0];
  assign hl      = {h_r, l_r};
  assign hl_step = (pair == PAIR_HL) ? hl + 16'd1 : hl - 16'd1;

  always_comb begin
    case (pair)
      PAIR_BC: pair_rd = {b_r, c_r};
      PAIR_DE: pair_rd = {d_r, e_r};
      PAIR_HL: pair_rd = hl;
      default: pair_rd = sp_r;
    endcase
    stk_rd = (pair == PAIR_TOP) ? {a_r, f_r} : pair_rd;
  end

  always_comb begin
    a_nxt = a_r; f_nxt = f_r; b_nxt = b_r; c_nxt = c_r;
    d_nxt = d_r; e_nxt = e_r; h_nxt = h_r; l_nxt = l_r;
    sp_nxt = sp_r; pc_nxt = pc_r;
    res_nxt = '0;

    case (item.action)
      ACT_RD8, ACT_WR8: begin
        if (item.reg_code == R8_MEM) begin
          res_nxt.bad_code = 1'b1;
        end else if (item.action == ACT_RD8) begin
          case (item.reg_code)
            R8_B:    res_nxt.read_data = {8'h00, b_r};
            R8_C:    res_nxt.read_data = {8'h00, c_r};
            R8_D:    res_nxt.read_data = {8'h00, d_r};
            R8_E:    res_nxt.read_data = {8'h00, e_r};
            R8_H:    res_nxt.read_data = {8'h00, h_r};
            R8_L:    res_nxt.read_data = {8'h00, l_r};
            default: res_nxt.read_data = {8'h00, a_r};
          endcase
        end else begin
          case (item.reg_code)
            R8_B:    b_nxt = item.write_value[7:0];
            R8_C:    c_nxt = item.write_value[7:0];
            R8_D:    d_nxt = item.write_value[7:0];
            R8_E:    e_nxt = item.write_value[7:0];
            R8_H:    h_nxt = item.write_value[7:0];
            R8_L:    l_nxt = item.write_value[7:0];
            default: a_nxt = item.write_value[7:0];
          endcase
        end
      end
      ACT_RD16, ACT_RDSTK: begin
        if (!pair_ok) res_nxt.bad_code = 1'b1;
        else res_nxt.read_data = (item.action == ACT_RDSTK) ? stk_rd : pair_rd;
      end
      ACT_WR16, ACT_WRSTK: begin
        if (!pair_ok) begin
          res_nxt.bad_code = 1'b1;
        end else begin
          case (pair)
            PAIR_BC: begin
              b_nxt = item.write_value[15:8]; c_nxt = item.write_value[7:0];
            end
            PAIR_DE: begin
              d_nxt = item.write_value[15:8]; e_nxt = item.write_value[7:0];
            end
            PAIR_HL: begin
              h_nxt = item.write_value[15:8]; l_nxt = item.write_value[7:0];
            end
            default: begin
              if (item.action == ACT_WRSTK) begin
                a_nxt = item.write_value[15:8];
                f_nxt = item.write_value[7:0] & F_HI_MASK;
              end else begin
                sp_nxt = item.write_value;
              end
            end
          endcase
        end
      end
      ACT_POINTER: begin
        if (!pair_ok) begin
          res_nxt.bad_code = 1'b1;
        end else if (pair == PAIR_BC || pair == PAIR_DE) begin
          res_nxt.read_data = pair_rd;
        end else begin
          // hl+ and hl- hand out the old value, then step with wrap
          res_nxt.read_data = hl;
          h_nxt = hl_step[15:8];
          l_nxt = hl_step[7:0];
        end
      end
      ACT_COND: begin
        case (item.cond_code)
          COND_NZ: res_nxt.cond_true = !f_r[FLAG_Z_BIT];
          COND_Z:  res_nxt.cond_true = f_r[FLAG_Z_BIT];
          COND_NC: res_nxt.cond_true = !f_r[FLAG_C_BIT];
          default: res_nxt.cond_true = f_r[FLAG_C_BIT];
        endcase
      end
      ACT_SETFLAGS: begin
        f_nxt[FLAG_Z_BIT] = flag_apply(f_r[FLAG_Z_BIT], item.zero_op);
        f_nxt[FLAG_N_BIT] = flag_apply(f_r[FLAG_N_BIT], item.subtract_op);
        f_nxt[FLAG_H_BIT] = flag_apply(f_r[FLAG_H_BIT], item.half_carry_op);
        f_nxt[FLAG_C_BIT] = flag_apply(f_r[FLAG_C_BIT], item.carry_op);
      end
      ACT_FETCHPC: begin
        res_nxt.read_data = pc_r;
        pc_nxt = pc_r + 16'd1;
      end
      default: begin
        res_nxt.bad_code = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= RST_A;
      f_r  <= flags_reset(1'b0);
      b_r  <= RST_B;
      c_r  <= RST_C;
      d_r  <= RST_D;
      e_r  <= RST_E;
      h_r  <= RST_H;
      l_r  <= RST_L;
      sp_r <= RST_SP;
      pc_r <= RST_PC;
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
      if (cfg_wr_en) begin
        // checksum setting reloads F with its reset value
        f_r <= flags_reset(cfg_wr_data);
      end else if (item_take) begin
        f_r <= f_nxt;
      end
      if (item_take) begin
        a_r  <= a_nxt;
        b_r  <= b_nxt;
        c_r  <= c_nxt;
        d_r  <= d_nxt;
        e_r  <= e_nxt;
        h_r  <= h_nxt;
        l_r  <= l_nxt;
        sp_r <= sp_nxt;
        pc_r <= pc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign result     = res_r;

`ifndef SYNTHESIS
  a_f_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    f_r[3:0] == 4'h0)
    else $error("low nibble of F is not zero");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && res_r.bad_code) |-> (res_r.read_data == 16'h0 && !res_r.cond_true))
    else $error("rejected access carries data");

  a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && item.action == ACT_FETCHPC && !cfg_wr_en)
      |=> (pc_r == $past(pc_r) + 16'd1))
    else $error("pc did not step on fetch");

  a_bad_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (item_take && res_nxt.bad_code && !cfg_wr_en)
      |=> ($stable(pc_r) && $stable(sp_r) && $stable({h_r, l_r}) && $stable(f_r)))
    else $error("rejected access changed state");
`endif

endmodule

>>> sv/sm83_register_file_core.sv
// ----------------------------------------------------------------------------
// sm83_register_file_core
// Register file of an 8-bit handheld cpu core with a streaming access port.
// ----------------------------------------------------------------------------
// Each input item is one access: in_tuser carries the action code, in_tdata
// the register code, write value, condition code and the four flag ops.
// Each accepted item yields exactly one result item on the out_ channel
// (read data, condition result and an invalid-code flag).
// An accepted item is held in the input register, then passes the decode and
// register update into the result register, which drives out_tvalid. The core
// takes one item per cycle while out_tready does not stall the result; the
// register update and the result for an item happen in the same cycle, so the
// next item always sees the state the previous one left.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item, then in_tready drops until out_tready returns.
// Reset (rst_n low, synchronous) loads the power-up register values, clears
// the checksum setting (F reads 0xB0) and empties both registers.
// cfg_wr_en writes header_checksum_zero and reloads F with its reset value;
// write it only while no item is in flight.
// ----------------------------------------------------------------------------
module sm83_register_file_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // header_checksum_zero
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] reg_code, [18:3] write_value, [20:19] cond_code, [22:21] zero_op,
  // [24:23] subtract_op, [26:25] half_carry_op, [28:27] carry_op, [31:29] zero
  input  logic [31:0] in_tdata,
  input  logic [3:0]  in_tuser,      // [3:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] read_data, [16] cond_true, [17] bad_code, [23:18] zero
  output logic [23:0] out_tdata
);
  import smrf_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_vld;
  logic    item_take;
  result_t result;

  always_comb begin
    in_item.action        = in_tuser;
    in_item.reg_code      = in_tdata[2:0];
    in_item.write_value   = in_tdata[18:3];
    in_item.cond_code     = in_tdata[20:19];
    in_item.zero_op       = in_tdata[22:21];
    in_item.subtract_op   = in_tdata[24:23];
    in_item.half_carry_op = in_tdata[26:25];
    in_item.carry_op      = in_tdata[28:27];
  end

  smrf_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take)
  );

  smrf_exec u_exec (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_vld    (item_vld),
    .item        (item),
    .item_take   (item_take),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .result      (result)
  );

  assign out_tdata = {6'b0, result.bad_code, result.cond_true, result.read_data};

endmodule
